// ===== rtl/core/mi3_pkg.sv =====
package mi3_pkg;

  localparam int ELEM_W   = 32;
  localparam int N_ELEM   = 9;
  localparam int COF_W    = 64;
  localparam int DET_W    = 98;
  localparam int DMAG_W   = 96;
  localparam int QUO_BITS = 31;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int QDEPTH   = 4;

  localparam logic [CFG_AW-1:0] REG_SINGULAR_LIMIT = 3'd0;
  localparam logic [31:0]       SINGULAR_LIMIT_RST = 32'd1;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // cofactor k = m[PA_A]*m[PA_B] - m[PB_A]*m[PB_B]
  localparam int PA_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PA_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PB_A [N_ELEM] = '{7, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PB_B [N_ELEM] = '{5, 8, 4, 8, 6, 5, 6, 7, 3};

  // classified item passed from front to back
  typedef struct packed {
    logic [N_ELEM-1:0][COF_W-1:0] cof;
    logic [DMAG_W-1:0]            dmag;
    logic                         dneg;
    logic                         sing;
  } cls_t;

endpackage

// ===== rtl/core/mi3_in_if.sv =====
interface mi3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// ===== rtl/core/mi3_out_if.sv =====
interface mi3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic        singular;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                  input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                output ready);
endinterface

// ===== rtl/core/mi3_front.sv =====
module mi3_front (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0] elems,
  input  logic [31:0]                                 limit,
  input  logic                                        q_space,
  output logic                                        push,
  output mi3_pkg::cls_t                               cls
);
  import mi3_pkg::*;

  logic                     fe;
  logic [7:1]               v_r;
  logic signed [63:0]       pa_r [N_ELEM];
  logic signed [63:0]       pb_r [N_ELEM];
  logic signed [31:0]       mc1_r [3];
  logic signed [31:0]       mc2_r [3];
  logic [N_ELEM-1:0][COF_W-1:0] c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;
  logic signed [64:0]       lo_r [3];
  logic signed [63:0]       hi_r [3];
  logic signed [DET_W-1:0]  term_r [3];
  logic signed [DET_W-1:0]  det_r;
  logic [DMAG_W-1:0]        dmag_r;
  logic                     dneg6_r, dneg7_r;
  logic [DMAG_W-1:0]        dmag7_r;
  logic                     sing_r;
  logic [DET_W-1:0]         det_abs;

  // whole front advances while the queue has room
  assign fe       = q_space;
  assign in_ready = fe;
  assign push     = fe & v_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe) begin
      v_r <= {v_r[6:1], in_valid};
    end
  end

  // stage 1: the eighteen element products
  for (genvar k = 0; k < N_ELEM; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (fe) begin
        pa_r[k] <= $signed(elems[PA_A[k]]) * $signed(elems[PA_B[k]]);
        pb_r[k] <= $signed(elems[PB_A[k]]) * $signed(elems[PB_B[k]]);
      end
    end
  end

  // stage 2: cofactors
  for (genvar j = 0; j < 3; j++) begin : g_col
    always_ff @(posedge clk) begin
      if (fe) begin
        mc1_r[j] <= $signed(elems[3*j]);
        mc2_r[j] <= mc1_r[j];
        // stage 3: partial products of column 0 times its cofactor
        lo_r[j]  <= mc2_r[j] * $signed({1'b0, c2_r[j][31:0]});
        hi_r[j]  <= mc2_r[j] * $signed(c2_r[j][63:32]);
        // stage 4: join partial products
        term_r[j] <= {{2{hi_r[j][63]}}, hi_r[j], 32'd0} + {{33{lo_r[j][64]}}, lo_r[j]};
      end
    end
  end

  for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (fe) begin
        c2_r[k] <= pa_r[k] - pb_r[k];
      end
    end
  end

  assign det_abs = det_r[DET_W-1] ? (DET_W)'(-det_r) : det_r;

  // stages 5 to 7: determinant, magnitude, threshold compare
  always_ff @(posedge clk) begin
    if (fe) begin
      c3_r    <= c2_r;
      c4_r    <= c3_r;
      c5_r    <= c4_r;
      c6_r    <= c5_r;
      c7_r    <= c6_r;
      det_r   <= term_r[0] + term_r[1] + term_r[2];
      dneg6_r <= det_r[DET_W-1];
      dmag_r  <= det_abs[DMAG_W-1:0];
      dneg7_r <= dneg6_r;
      dmag7_r <= dmag_r;
      sing_r  <= (dmag_r == '0) || (dmag_r < {32'd0, limit, 32'd0});
    end
  end

  assign cls.cof  = c7_r;
  assign cls.dmag = dmag7_r;
  assign cls.dneg = dneg7_r;
  assign cls.sing = sing_r;
endmodule

// ===== rtl/core/mi3_queue.sv =====
module mi3_queue #(
  parameter int DEPTH = mi3_pkg::QDEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mi3_pkg::cls_t push_data,
  output logic          space,
  input  logic          pop,
  output logic          head_valid,
  output mi3_pkg::cls_t head
);
  import mi3_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // pointers wrap at the last entry, so any depth works
  cls_t          mem [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;

  assign space      = cnt_r < (AW+1)'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== rtl/core/mi3_back.sv =====
module mi3_back (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        head_valid,
  input  mi3_pkg::cls_t                               head,
  output logic                                        pop,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0] res,
  output logic                                        singular
);
  import mi3_pkg::*;

  localparam int NS = QUO_BITS + 1;

  logic                       be;
  // stage a: cofactor magnitudes
  logic                       va_r;
  logic [COF_W-1:0]           cm_r [N_ELEM];
  logic                       nga_r [N_ELEM];
  logic [DMAG_W-1:0]          da_r;
  logic                       sga_r;
  // divider stages, index 0 holds the overflow check result
  logic                       v_r   [NS];
  logic [DMAG_W-1:0]          d_r   [NS];
  logic                       sg_r  [NS];
  logic [DMAG_W-1:0]          rem_r [NS][N_ELEM];
  logic [QUO_BITS-1:0]        q_r   [NS][N_ELEM];
  logic                       ng_r  [NS][N_ELEM];
  logic                       ov_r  [NS][N_ELEM];
  logic                       out_valid_r;
  logic [N_ELEM-1:0][ELEM_W-1:0] res_r;
  logic                       sing_r;

  // back advances when the output register is free or being taken
  assign be  = !out_valid_r || out_ready;
  assign pop = be && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (be) begin
      va_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      da_r  <= head.dmag;
      sga_r <= head.sing;
    end
  end

  for (genvar l = 0; l < N_ELEM; l++) begin : g_lane
    logic [COF_W-1:0] cof;
    logic [127:0]     lim;
    assign cof = head.cof[l];
    assign lim = {32'd0, da_r} << QUO_BITS;

    always_ff @(posedge clk) begin
      if (be) begin
        cm_r[l]     <= cof[COF_W-1] ? (COF_W)'(-cof) : cof;
        nga_r[l]    <= cof[COF_W-1] ^ head.dneg;
        // quotient of 2^31 or more saturates either way
        rem_r[0][l] <= {cm_r[l], 32'd0};
        q_r[0][l]   <= '0;
        ng_r[0][l]  <= nga_r[l];
        ov_r[0][l]  <= {32'd0, cm_r[l], 32'd0} >= lim;
      end
    end

    // one restoring step per stage
    for (genvar s = 0; s < QUO_BITS; s++) begin : g_step
      logic [127:0] diff;
      assign diff = {32'd0, rem_r[s][l]} - ({32'd0, d_r[s]} << (QUO_BITS - 1 - s));
      always_ff @(posedge clk) begin
        if (be) begin
          if (!diff[127]) begin
            rem_r[s+1][l] <= diff[DMAG_W-1:0];
            q_r[s+1][l]   <= q_r[s][l] | (QUO_BITS)'(1) << (QUO_BITS - 1 - s);
          end else begin
            rem_r[s+1][l] <= rem_r[s][l];
            q_r[s+1][l]   <= q_r[s][l];
          end
          ng_r[s+1][l] <= ng_r[s][l];
          ov_r[s+1][l] <= ov_r[s][l];
        end
      end
    end

    // sign, saturation and singular zeroing into the output register
    always_ff @(posedge clk) begin
      if (be) begin
        if (sg_r[NS-1]) begin
          res_r[l] <= '0;
        end else if (ov_r[NS-1][l]) begin
          res_r[l] <= ng_r[NS-1][l] ? SAT_NEG : SAT_POS;
        end else if (ng_r[NS-1][l]) begin
          res_r[l] <= -{1'b0, q_r[NS-1][l]};
        end else begin
          res_r[l] <= {1'b0, q_r[NS-1][l]};
        end
      end
    end
  end

  // per-item control carried with the divider stages
  always_ff @(posedge clk) begin
    if (be) begin
      d_r[0]  <= da_r;
      sg_r[0] <= sga_r;
      for (int s = 1; s < NS; s++) begin
        d_r[s]  <= d_r[s-1];
        sg_r[s] <= sg_r[s-1];
      end
      sing_r <= sg_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (be) begin
      v_r[0] <= va_r;
      for (int s = 1; s < NS; s++) v_r[s] <= v_r[s-1];
      out_valid_r <= v_r[NS-1];
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign singular  = sing_r;
endmodule

// ===== rtl/core/matrix_inverse_3x3.sv =====
// throughput: one item per cycle; the front pipeline (7 stages) stalls only
// when its 4-entry queue is full, the divider stalls with the output
// register; each stage runs one wide add/compare or 32x33 or narrower
// multiplies
// reset: synchronous active-low rst_n clears valid state and queue pointers,
// singular_limit returns to 1
module matrix_inverse_3x3 #(
  parameter int QDEPTH = mi3_pkg::QDEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mi3_in_if.sink                      in_ch,
  mi3_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mi3_pkg::CFG_AW-1:0]  paddr,
  input  logic [mi3_pkg::CFG_DW-1:0]  pwdata,
  output logic [mi3_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import mi3_pkg::*;

  logic [31:0]                    limit_r;
  logic [N_ELEM-1:0][ELEM_W-1:0]  elems;
  logic [N_ELEM-1:0][ELEM_W-1:0]  res;
  logic                           q_space, push, pop, head_valid;
  cls_t                           cls, head;
  logic                           reg_hit;

  // config register, word aligned
  assign reg_hit = paddr[CFG_AW-1:2] == REG_SINGULAR_LIMIT[CFG_AW-1:2];
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? limit_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= SINGULAR_LIMIT_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      limit_r <= pwdata;
    end
  end

  assign elems = {in_ch.m22, in_ch.m21, in_ch.m20, in_ch.m12, in_ch.m11, in_ch.m10,
                  in_ch.m02, in_ch.m01, in_ch.m00};

  mi3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .elems    (elems),
    .limit    (limit_r),
    .q_space  (q_space),
    .push     (push),
    .cls      (cls)
  );

  mi3_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (cls),
    .space      (q_space),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mi3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .res        (res),
    .singular   (out_ch.singular)
  );

  assign out_ch.r00 = res[0];
  assign out_ch.r01 = res[1];
  assign out_ch.r02 = res[2];
  assign out_ch.r10 = res[3];
  assign out_ch.r11 = res[4];
  assign out_ch.r12 = res[5];
  assign out_ch.r20 = res[6];
  assign out_ch.r21 = res[7];
  assign out_ch.r22 = res[8];
endmodule

// ===== rtl/core/mi3_chk.sv =====
module mi3_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        singular,
  input logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
  input logic        pready
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // singular matrices give an all-zero inverse
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && singular |-> r00 == 0 && r01 == 0 && r02 == 0 && r10 == 0 &&
      r11 == 0 && r12 == 0 && r20 == 0 && r21 == 0 && r22 == 0)
    else $error("singular item with nonzero elements");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("config port stalled");

endmodule

bind matrix_inverse_3x3 mi3_chk u_mi3_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .singular  (out_ch.singular),
  .r00       (out_ch.r00),
  .r01       (out_ch.r01),
  .r02       (out_ch.r02),
  .r10       (out_ch.r10),
  .r11       (out_ch.r11),
  .r12       (out_ch.r12),
  .r20       (out_ch.r20),
  .r21       (out_ch.r21),
  .r22       (out_ch.r22),
  .pready    (pready)
);
